// ===== sv/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types, codes and constants of the BMP pixel unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

  // palette storage
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT  = 3'd0,
    REG_RED_MASK      = 3'd1,
    REG_GREEN_MASK    = 3'd2,
    REG_BLUE_MASK     = 3'd3,
    REG_ALPHA_MASK    = 3'd4,
    REG_PALETTE_COUNT = 3'd5
  } reg_idx_t;

  // pixel formats
  typedef enum logic [1:0] {
    FMT_PALETTE8 = 2'd0,
    FMT_MASK16   = 2'd1,
    FMT_BGR24    = 2'd2,
    FMT_MASK32   = 2'd3
  } fmt_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PAL_RANGE = 2'd1,
    ST_BAD_MASK  = 2'd2
  } status_t;

  // input item modes
  localparam logic MODE_PAL_WRITE = 1'b0;
  localparam logic MODE_CONVERT   = 1'b1;

  // reset values of the configuration registers
  localparam logic [31:0] RED_MASK_RST   = 32'h00ff_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_ff00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00ff;
  localparam logic [31:0] ALPHA_MASK_RST = 32'h0000_0000;
  localparam logic [8:0]  PAL_COUNT_RST  = 9'd256;
  localparam logic [7:0]  OPAQUE         = 8'hff;

  // decoded channel mask: contiguous flag, lowest bit and run length
  typedef struct packed {
    logic       ok;
    logic [4:0] pos;
    logic [5:0] len;
  } mask_info_t;

  // channel byte source in the last stage
  typedef enum logic {
    SEL_DIRECT = 1'b0,
    SEL_WIDEN  = 1'b1
  } chan_sel_t;

  // reciprocals for (x / (2^len - 1)), exact for x below 2^15
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam longint RECIP_ONE = 64'd1 << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_L1 = RECIP_W'(RECIP_ONE);
  localparam logic [RECIP_W-1:0] RECIP_L2 = RECIP_W'((RECIP_ONE + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_L3 = RECIP_W'((RECIP_ONE + 6) / 7);
  localparam logic [RECIP_W-1:0] RECIP_L4 = RECIP_W'((RECIP_ONE + 14) / 15);
  localparam logic [RECIP_W-1:0] RECIP_L5 = RECIP_W'((RECIP_ONE + 30) / 31);
  localparam logic [RECIP_W-1:0] RECIP_L6 = RECIP_W'((RECIP_ONE + 62) / 63);
  localparam logic [RECIP_W-1:0] RECIP_L7 = RECIP_W'((RECIP_ONE + 126) / 127);

  // reciprocal of the channel maximum for a run of 1 to 7 bits
  function automatic logic [RECIP_W-1:0] widen_recip(input logic [2:0] len);
    logic [RECIP_W-1:0] r;
    unique case (len)
      3'd1:    r = RECIP_L1;
      3'd2:    r = RECIP_L2;
      3'd3:    r = RECIP_L3;
      3'd4:    r = RECIP_L4;
      3'd5:    r = RECIP_L5;
      3'd6:    r = RECIP_L6;
      3'd7:    r = RECIP_L7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/bpu_mask_dec.sv =====
// ----------------------------------------------------------------------------
// bpu_mask_dec
// Checks that a channel mask is one run of bits and finds its position and
// length.
// ----------------------------------------------------------------------------
module bpu_mask_dec
  import bpu_pkg::*;
(
  input  logic [31:0] mask,
  output mask_info_t  info
);

  logic [31:0] lowbit;
  logic [32:0] above;
  logic [4:0]  pos;
  logic [5:0]  hi;

  // isolate the lowest set bit and carry it through the run
  assign lowbit = mask & (~mask + 32'd1);
  assign above  = {1'b0, mask} + {1'b0, lowbit};

  // encode the one-hot start and end of the run
  always_comb begin
    pos = '0;
    hi  = '0;
    for (int i = 0; i < 32; i++) begin
      pos = pos | (lowbit[i] ? 5'(i) : 5'd0);
    end
    for (int i = 0; i < 33; i++) begin
      hi = hi | (above[i] ? 6'(i) : 6'd0);
    end
  end

  assign info.ok  = (mask != 32'd0) && ((above[31:0] & mask) == 32'd0);
  assign info.pos = pos;
  assign info.len = hi - {1'b0, pos};

endmodule

// ===== sv/bpu_chan.sv =====
// ----------------------------------------------------------------------------
// bpu_chan
// Last two stages of one color channel: truncate, pass or widen the raw
// field to 8 bits, with a forced byte for fixed formats and error cases.
// ----------------------------------------------------------------------------
module bpu_chan
  import bpu_pkg::*;
(
  input  logic        clk,
  input  logic        ld3,
  input  logic        ld4,
  input  logic [31:0] field,
  input  mask_info_t  info,
  input  logic        force_en,
  input  logic [7:0]  force_byte,
  output logic [7:0]  chan_byte
);

  chan_sel_t          sel3;
  logic [7:0]         byte3;
  logic [14:0]        x3;
  logic [RECIP_W-1:0] recip3;

  chan_sel_t          sel_next;
  logic [7:0]         byte_next;
  logic [14:0]        x_next;
  logic [2:0]         lw;
  logic [6:0]         top;
  logic [6:0]         raw;
  logic [4:0]         tshift;
  logic [39:0]        prod;

  // narrow runs: raw * 255 + max / 2, divided by max in the next stage
  assign lw     = info.len[2:0];
  assign top    = 7'(~(7'h7f << lw));
  assign raw    = field[6:0] & top;
  assign tshift = 5'(info.len - 6'd8);
  assign x_next = {raw, 8'h00} - 15'(raw) + 15'(top >> 1);

  // pick the byte source
  always_comb begin
    sel_next  = SEL_DIRECT;
    byte_next = field[7:0];
    if (force_en) begin
      byte_next = force_byte;
    end else if (info.len > 6'd8) begin
      byte_next = 8'(field >> tshift);
    end else if (info.len < 6'd8) begin
      sel_next = SEL_WIDEN;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (ld3) begin
      sel3   <= sel_next;
      byte3  <= byte_next;
      x3     <= x_next;
      recip3 <= widen_recip(lw);
    end
  end

  // stage 4: reciprocal multiply
  assign prod = 40'(x3) * 40'(recip3);

  always_ff @(posedge clk) begin
    if (ld4) begin
      chan_byte <= (sel3 == SEL_WIDEN) ? prod[RECIP_SHIFT +: 8] : byte3;
    end
  end

endmodule

// ===== sv/bmp_pixel_unpacker.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker
// Converts BMP pixel words (palette, BGR or bit-field formats) to 8-bit RGBA.
// ----------------------------------------------------------------------------
//  channel  | dir | width | contents
//  s_axis   | in  | 64+1  | palette write or pixel word, tuser selects
//  m_axis   | out | 32+2  | RGBA result, tuser carries status
//  cfg      | in  | 3+32  | register index and write data
//
//  One item per cycle while the output is not stalled; a convert item passes
//  through the input, extract, channel select and reciprocal multiply stages.
//  Palette write items update the palette as they are accepted and give
//  no result. Each stage has its own valid bit and loads when the stage
//  after it is empty or moving, so bubbles close up under stalls.
//  Reset is synchronous; it restores the registers and empties the pipe.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker
  import bpu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // tdata: palette_slot, entry_red, entry_green, entry_blue, pixel_word
  input  logic [63:0]          s_axis_tdata,
  // tuser: mode
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: out_red, out_green, out_blue, out_alpha
  output logic [31:0]          m_axis_tdata,
  // tuser: status
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration registers
  fmt_t        pixel_format;
  logic [31:0] red_mask;
  logic [31:0] green_mask;
  logic [31:0] blue_mask;
  logic [31:0] alpha_mask;
  logic [8:0]  palette_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= FMT_MASK32;
      red_mask      <= RED_MASK_RST;
      green_mask    <= GREEN_MASK_RST;
      blue_mask     <= BLUE_MASK_RST;
      alpha_mask    <= ALPHA_MASK_RST;
      palette_count <= PAL_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT:  pixel_format  <= fmt_t'(cfg_data[1:0]);
        REG_RED_MASK:      red_mask      <= cfg_data;
        REG_GREEN_MASK:    green_mask    <= cfg_data;
        REG_BLUE_MASK:     blue_mask     <= cfg_data;
        REG_ALPHA_MASK:    alpha_mask    <= cfg_data;
        REG_PALETTE_COUNT: palette_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // mask decode, registered every cycle from the static configuration
  mask_info_t red_dec, green_dec, blue_dec, alpha_dec;
  mask_info_t red_info, green_info, blue_info, alpha_info;
  logic       rgb_ok;

  bpu_mask_dec u_red_dec   (.mask(red_mask),   .info(red_dec));
  bpu_mask_dec u_green_dec (.mask(green_mask), .info(green_dec));
  bpu_mask_dec u_blue_dec  (.mask(blue_mask),  .info(blue_dec));
  bpu_mask_dec u_alpha_dec (.mask(alpha_mask), .info(alpha_dec));

  always_ff @(posedge clk) begin
    red_info   <= red_dec;
    green_info <= green_dec;
    blue_info  <= blue_dec;
    alpha_info <= alpha_dec;
    rgb_ok     <= red_dec.ok && green_dec.ok && blue_dec.ok &&
                  ((red_mask & green_mask) == 32'd0) &&
                  ((red_mask & blue_mask) == 32'd0) &&
                  ((green_mask & blue_mask) == 32'd0);
  end

  // pipeline flow control
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld2, ld3, ld4;
  logic accept;

  assign rdy4   = !v4 || m_axis_tready;
  assign rdy3   = !v3 || rdy4;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;
  assign ld2    = v1 && rdy2;
  assign ld3    = v2 && rdy3;
  assign ld4    = v3 && rdy4;
  assign accept = s_axis_tvalid && rdy1;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid && (s_axis_tuser == MODE_CONVERT);
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // palette writes happen on acceptance, ahead of any later read
  logic [23:0] palette_mem [PALETTE_DEPTH];
  logic [7:0]  wr_slot;
  logic        wr_en;

  assign wr_slot = s_axis_tdata[7:0];
  assign wr_en   = accept && (s_axis_tuser == MODE_PAL_WRITE) &&
                   ({1'b0, wr_slot} < 9'(PALETTE_DEPTH));

  // entry kept as red, green, blue from the top byte down
  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[wr_slot[PAL_AW-1:0]] <= {s_axis_tdata[15:8], s_axis_tdata[23:16],
                                           s_axis_tdata[31:24]};
    end
  end

  // stage 1: convert item
  logic [31:0] word1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      word1 <= s_axis_tdata[63:32];
    end
  end

  // stage 1 to 2: palette read, range check, field extraction
  logic [31:0] px;
  logic [8:0]  pal_limit;
  logic        pal_err;
  status_t     st_next;

  assign px        = (pixel_format == FMT_MASK16) ? {16'h0000, word1[15:0]} : word1;
  assign pal_limit = (palette_count < 9'(PALETTE_DEPTH)) ? palette_count
                                                          : 9'(PALETTE_DEPTH);
  assign pal_err   = {1'b0, word1[7:0]} >= pal_limit;

  always_comb begin
    unique case (pixel_format)
      FMT_PALETTE8:         st_next = pal_err ? ST_PAL_RANGE : ST_OK;
      FMT_BGR24:            st_next = ST_OK;
      FMT_MASK16, FMT_MASK32: st_next = rgb_ok ? ST_OK : ST_BAD_MASK;
      default:              st_next = ST_OK;
    endcase
  end

  logic [23:0] pal_q;
  logic [23:0] word2;
  logic [31:0] red_f2, green_f2, blue_f2, alpha_f2;
  status_t     st2;
  fmt_t        fmt2;

  always_ff @(posedge clk) begin
    if (ld2) begin
      pal_q    <= palette_mem[word1[PAL_AW-1:0]];
      word2    <= word1[23:0];
      red_f2   <= px >> red_info.pos;
      green_f2 <= px >> green_info.pos;
      blue_f2  <= px >> blue_info.pos;
      alpha_f2 <= px >> alpha_info.pos;
      st2      <= st_next;
      fmt2     <= pixel_format;
    end
  end

  // stage 2 to 3: forced bytes for fixed formats and error cases
  logic       red_force, green_force, blue_force, alpha_force;
  logic [7:0] red_fb, green_fb, blue_fb, alpha_fb;

  always_comb begin
    red_force   = 1'b1;
    green_force = 1'b1;
    blue_force  = 1'b1;
    alpha_force = 1'b1;
    red_fb      = 8'h00;
    green_fb    = 8'h00;
    blue_fb     = 8'h00;
    alpha_fb    = 8'h00;
    unique case (fmt2)
      FMT_PALETTE8: begin
        if (st2 == ST_OK) begin
          red_fb   = pal_q[23:16];
          green_fb = pal_q[15:8];
          blue_fb  = pal_q[7:0];
          alpha_fb = OPAQUE;
        end
      end
      FMT_BGR24: begin
        red_fb   = word2[23:16];
        green_fb = word2[15:8];
        blue_fb  = word2[7:0];
        alpha_fb = OPAQUE;
      end
      FMT_MASK16, FMT_MASK32: begin
        if (st2 == ST_OK) begin
          red_force   = 1'b0;
          green_force = 1'b0;
          blue_force  = 1'b0;
          alpha_force = !alpha_info.ok;
          alpha_fb    = OPAQUE;
        end
      end
      default: ;
    endcase
  end

  // per-channel select and widen stages
  logic [7:0] red_out, green_out, blue_out, alpha_out;

  bpu_chan u_red (
    .clk(clk), .ld3(ld3), .ld4(ld4), .field(red_f2), .info(red_info),
    .force_en(red_force), .force_byte(red_fb), .chan_byte(red_out)
  );
  bpu_chan u_green (
    .clk(clk), .ld3(ld3), .ld4(ld4), .field(green_f2), .info(green_info),
    .force_en(green_force), .force_byte(green_fb), .chan_byte(green_out)
  );
  bpu_chan u_blue (
    .clk(clk), .ld3(ld3), .ld4(ld4), .field(blue_f2), .info(blue_info),
    .force_en(blue_force), .force_byte(blue_fb), .chan_byte(blue_out)
  );
  bpu_chan u_alpha (
    .clk(clk), .ld3(ld3), .ld4(ld4), .field(alpha_f2), .info(alpha_info),
    .force_en(alpha_force), .force_byte(alpha_fb), .chan_byte(alpha_out)
  );

  // status travels alongside the channel stages
  status_t st3, st4;

  always_ff @(posedge clk) begin
    if (ld3) st3 <= st2;
    if (ld4) st4 <= st3;
  end

  // output item
  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {alpha_out, blue_out, green_out, red_out};
  assign m_axis_tuser  = st4;

endmodule

// ===== verif/bmp_pixel_unpacker_tb.sv =====
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker_tb
// Self-checking bench for the BMP pixel unpacker. Palette loads and pixel
// words stream in with random gaps and output stalls. A scoreboard keeps its
// own copy of the registers and palette, predicts the RGBA result and status
// of each convert item, and checks results in order. A directed part covers
// reset settings, all four pixel formats, palette limits and bad masks. It is
// followed by random register settings, each with a burst of random items.
// ----------------------------------------------------------------------------
module bmp_pixel_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_DRAIN     = 8;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 100;

  // one predicted pixel result
  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    status_t    st;
  } rgba_t;

  // decoded mask: contiguous flag, lowest set bit and run length
  typedef struct {
    bit ok;
    int pos;
    int len;
  } bit_run_t;

  // one full register setting
  typedef struct {
    fmt_t        fmt;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
    logic [8:0]  count;
  } pix_cfg_t;

  // scoreboard: register and palette copy, pixel predictor, result checker
  class rgba_scoreboard;
    fmt_t        fmt;
    logic [31:0] red_mask;
    logic [31:0] green_mask;
    logic [31:0] blue_mask;
    logic [31:0] alpha_mask;
    logic [8:0]  pal_count;
    logic [23:0] palette [PALETTE_DEPTH];
    bit          pal_written [PALETTE_DEPTH];
    rgba_t       rgba_pending [$];
    int          errors;
    int          n_inputs;
    int          n_writes;
    int          n_results;

    function new();
      fmt        = FMT_MASK32;
      red_mask   = RED_MASK_RST;
      green_mask = GREEN_MASK_RST;
      blue_mask  = BLUE_MASK_RST;
      alpha_mask = ALPHA_MASK_RST;
      pal_count  = PAL_COUNT_RST;
      errors     = 0;
      n_inputs   = 0;
      n_writes   = 0;
      n_results  = 0;
    endfunction

    function int pending();
      return rgba_pending.size();
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_PIXEL_FORMAT:  fmt = fmt_t'(v[1:0]);
        REG_RED_MASK:      red_mask = v;
        REG_GREEN_MASK:    green_mask = v;
        REG_BLUE_MASK:     blue_mask = v;
        REG_ALPHA_MASK:    alpha_mask = v;
        REG_PALETTE_COUNT: pal_count = v[8:0];
        default: ;
      endcase
    endfunction

    // contiguity check of a channel mask
    function bit_run_t decode_mask(logic [31:0] m);
      bit_run_t   d;
      logic [32:0] run;
      d = '{ok: 1'b0, pos: 0, len: 0};
      if (m == 32'd0) return d;
      while (m[d.pos] == 1'b0) d.pos++;
      run   = {1'b0, m} >> d.pos;
      d.ok  = ((run & (run + 33'd1)) == 33'd0);
      d.len = $countones(run);
      return d;
    endfunction

    // cut out a channel and bring it to 8 bits
    function logic [7:0] channel_byte(logic [31:0] px, bit_run_t d);
      longint unsigned raw;
      longint unsigned top;
      top = (64'd1 << d.len) - 64'd1;
      raw = ({32'd0, px} >> d.pos) & top;
      if (d.len > 8) return 8'(raw >> (d.len - 8));
      if (d.len == 8) return 8'(raw);
      return 8'((raw * 255 + top / 2) / top);
    endfunction

    function rgba_t convert_pixel(logic [31:0] word);
      rgba_t       o;
      bit_run_t    rd, gd, bd, ad;
      logic [31:0] px;
      int          lim;
      o = '{r: 8'd0, g: 8'd0, b: 8'd0, a: OPAQUE, st: ST_OK};
      case (fmt)
        FMT_PALETTE8: begin
          lim = (pal_count < PALETTE_DEPTH) ? int'(pal_count) : PALETTE_DEPTH;
          if (int'(word[7:0]) >= lim) begin
            o.st = ST_PAL_RANGE;
            o.a  = 8'd0;
          end else begin
            {o.r, o.g, o.b} = palette[word[7:0]];
          end
        end
        FMT_BGR24: begin
          {o.r, o.g, o.b} = word[23:0];
        end
        default: begin
          px = (fmt == FMT_MASK16) ? {16'd0, word[15:0]} : word;
          rd = decode_mask(red_mask);
          gd = decode_mask(green_mask);
          bd = decode_mask(blue_mask);
          ad = decode_mask(alpha_mask);
          if (!rd.ok || !gd.ok || !bd.ok || (red_mask & green_mask) != 0 ||
              (red_mask & blue_mask) != 0 || (green_mask & blue_mask) != 0) begin
            o.st = ST_BAD_MASK;
            o.a  = 8'd0;
          end else begin
            o.r = channel_byte(px, rd);
            o.g = channel_byte(px, gd);
            o.b = channel_byte(px, bd);
            if (ad.ok) o.a = channel_byte(px, ad);
          end
        end
      endcase
      return o;
    endfunction

    // accepted input item: palette load or pixel to predict
    function void note_input(logic mode, logic [63:0] data);
      n_inputs++;
      if (mode == MODE_PAL_WRITE) begin
        n_writes++;
        palette[data[7:0]]     = {data[15:8], data[23:16], data[31:24]};
        pal_written[data[7:0]] = 1'b1;
      end else begin
        rgba_pending.push_back(convert_pixel(data[63:32]));
      end
    endfunction

    // accepted result item against the oldest prediction
    function void check_output(logic [31:0] data, logic [1:0] st);
      rgba_t e;
      n_results++;
      if (rgba_pending.size() == 0) begin
        errors++;
        $error("result with no pending pixel: data %h status %0d", data, st);
        return;
      end
      e = rgba_pending.pop_front();
      if (data[7:0] !== e.r) begin
        errors++;
        $error("out_red: expected %0d, got %0d", e.r, data[7:0]);
      end
      if (data[15:8] !== e.g) begin
        errors++;
        $error("out_green: expected %0d, got %0d", e.g, data[15:8]);
      end
      if (data[23:16] !== e.b) begin
        errors++;
        $error("out_blue: expected %0d, got %0d", e.b, data[23:16]);
      end
      if (data[31:24] !== e.a) begin
        errors++;
        $error("out_alpha: expected %0d, got %0d", e.a, data[31:24]);
      end
      if (st !== e.st) begin
        errors++;
        $error("status: expected %0d, got %0d", e.st, st);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic [63:0]          s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  rgba_scoreboard rgba_sb;
  bit             tx_steady;
  bit             rx_steady;
  int             n_settings;

  bmp_pixel_unpacker u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always #4 clk = ~clk;

  function automatic logic [31:0] bit_run(int pos, int len);
    return 32'(((64'd1 << len) - 64'd1) << pos);
  endfunction

  // send one item; handshake is sampled on the falling edge before acceptance
  task automatic send_item(logic mode, logic [7:0] slot, logic [7:0] er,
                           logic [7:0] eg, logic [7:0] eb, logic [31:0] word);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {word, eb, eg, er, slot};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    rgba_sb.note_input(mode, {word, eb, eg, er, slot});
    @(posedge clk);
  endtask

  task automatic pal_write(logic [7:0] slot, logic [7:0] er, logic [7:0] eg,
                           logic [7:0] eb);
    send_item(MODE_PAL_WRITE, slot, er, eg, eb, $urandom);
  endtask

  task automatic convert(logic [31:0] word);
    send_item(MODE_CONVERT, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), word);
  endtask

  // sender holds off until every pending pixel has come out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (rgba_sb.pending() != 0);
  endtask

  // cfg_write stays high across back-to-back register writes
  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    rgba_sb.set_reg(idx, v);
  endtask

  task automatic configure(pix_cfg_t c);
    hold_until_drained();
    repeat (PIPE_DRAIN) @(posedge clk);
    write_reg(REG_PIXEL_FORMAT, 32'(c.fmt));
    write_reg(REG_RED_MASK, c.red);
    write_reg(REG_GREEN_MASK, c.green);
    write_reg(REG_BLUE_MASK, c.blue);
    write_reg(REG_ALPHA_MASK, c.alpha);
    write_reg(REG_PALETTE_COUNT, 32'(c.count));
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // random register setting followed by a burst of random items
  task automatic run_random_phase(int n_items);
    pix_cfg_t    c;
    logic [31:0] m [3];
    logic [31:0] word;
    int          w, pos, gap, len, room, k, sel, lim, idx;
    c.fmt = fmt_t'($urandom_range(0, 3));
    w = (c.fmt == FMT_MASK16 && $urandom_range(0, 7) != 0) ? 16 : 32;
    pos = $urandom_range(0, (w == 32) ? 8 : 2);
    // three disjoint runs placed low to high
    for (k = 0; k < 3; k++) begin
      gap = $urandom_range(0, 2);
      if (pos + gap + (3 - k) > w) gap = 0;
      room = w - pos - gap - (2 - k);
      len  = $urandom_range(1, (room < 12) ? room : 12);
      m[k] = bit_run(pos + gap, len);
      pos  += gap + len;
    end
    sel     = $urandom_range(0, 2);
    c.red   = m[sel];
    c.green = m[(sel + 1) % 3];
    c.blue  = m[(sel + 2) % 3];
    if ($urandom_range(0, 1) == 1) begin
      c.green = m[(sel + 2) % 3];
      c.blue  = m[(sel + 1) % 3];
    end
    // occasionally overlapping, empty or scattered masks
    case ($urandom_range(0, 15))
      0:       c.green = c.red;
      1:       c.blue = 32'd0;
      2:       c.red = $urandom;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0, 1:    c.alpha = 32'd0;
      2:       c.alpha = bit_run(0, 1) | bit_run($urandom_range(2, 31), 1);
      3:       c.alpha = $urandom;
      default: begin
        if (pos < w) c.alpha = bit_run(pos, $urandom_range(1, w - pos));
        else         c.alpha = bit_run($urandom_range(0, 23), $urandom_range(1, 8));
      end
    endcase
    case ($urandom_range(0, 7))
      0:       c.count = 9'd256;
      1:       c.count = 9'd1;
      2:       c.count = 9'd0;
      3:       c.count = 9'd255;
      default: c.count = 9'($urandom_range(2, 254));
    endcase
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    configure(c);

    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) == 0) hold_until_drained();
      case ($urandom_range(0, 15))
        0:       word = 32'd0;
        1:       word = 32'hffff_ffff;
        default: word = $urandom;
      endcase
      if (rgba_sb.fmt == FMT_PALETTE8) begin
        lim = (rgba_sb.pal_count < PALETTE_DEPTH) ? int'(rgba_sb.pal_count)
                                                  : PALETTE_DEPTH;
        if ($urandom_range(0, 3) == 0) begin
          pal_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (lim < PALETTE_DEPTH && (lim == 0 || $urandom_range(0, 3) == 0)) begin
          idx = $urandom_range(lim, 255);
          convert({word[31:8], 8'(idx)});
        end else begin
          // only read palette entries that hold a value; load the rest first
          idx = $urandom_range(0, lim - 1);
          if (rgba_sb.pal_written[idx])
            convert({word[31:8], 8'(idx)});
          else
            pal_write(8'(idx), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end else if ($urandom_range(0, 9) == 0) begin
        pal_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        convert(word);
      end
    end
  endtask

  // result side: random stall per item, checked on the falling edge
  initial begin
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!rx_steady && $urandom_range(0, 11) != 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
      while (!m_axis_tvalid) @(negedge clk);
      rgba_sb.check_output(m_axis_tdata, m_axis_tuser);
      @(posedge clk);
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin
    int p;
    rgba_sb       = new();
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    n_settings    = 0;
    rst           = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = REG_PIXEL_FORMAT;
    cfg_data      = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 32 bpp with standard masks, no alpha
    convert(32'h0000_0000);
    convert(32'hffff_ffff);

    // palette loads, extremes of the index, count limits
    configure('{FMT_PALETTE8, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                ALPHA_MASK_RST, 9'd256});
    pal_write(8'd0, 8'h00, 8'h00, 8'h00);
    pal_write(8'd255, 8'hff, 8'hff, 8'hff);
    pal_write(8'h5a, 8'h12, 8'h34, 8'h56);
    convert(32'hffff_ff00);
    convert(32'h0000_00ff);
    convert(32'h1234_565a);
    configure('{FMT_PALETTE8, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                ALPHA_MASK_RST, 9'h05b});
    convert(32'h0000_005a);
    convert(32'h0000_005b);
    configure('{FMT_PALETTE8, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                ALPHA_MASK_RST, 9'd1});
    convert(32'h0000_0000);
    convert(32'h0000_0001);
    // zero count rejects every index
    configure('{FMT_PALETTE8, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                ALPHA_MASK_RST, 9'd0});
    convert(32'h0000_0000);

    // bgr byte order, top byte ignored
    configure('{FMT_BGR24, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                ALPHA_MASK_RST, 9'd256});
    convert(32'hffff_ffff);
    convert(32'h0000_0000);
    convert(32'ha1b2_c3d4);

    // 16 bpp 565 widening, upper half of the word ignored
    configure('{FMT_MASK16, 32'h0000_f800, 32'h0000_07e0, 32'h0000_001f,
                32'h0000_0000, 9'd256});
    convert(32'h0000_ffff);
    convert(32'hffff_0000);
    // 16 bpp 1555 with one-bit alpha
    configure('{FMT_MASK16, 32'h0000_7c00, 32'h0000_03e0, 32'h0000_001f,
                32'h0000_8000, 9'd256});
    convert(32'h0000_8000);
    convert(32'h0000_7fff);
    // 16 bpp with a mask above bit 15 reads zero
    configure('{FMT_MASK16, 32'h000f_0000, 32'h0000_00f0, 32'h0000_000f,
                32'h0000_ff00, 9'd256});
    convert(32'hffff_ffff);

    // 32 bpp wide channel truncated, one-bit channel, 6-bit alpha
    configure('{FMT_MASK32, 32'hffff_0000, 32'h0000_ff00, 32'h0000_0080,
                32'h0000_007e, 9'd256});
    convert(32'hffff_ffff);
    convert(32'h7fff_00d5);
    // 10-bit channels, alpha in the top two bits
    configure('{FMT_MASK32, 32'h0000_03ff, 32'h000f_fc00, 32'h3ff0_0000,
                32'hc000_0000, 9'd256});
    convert(32'h4aaa_aaaa);
    // scattered alpha mask gives opaque alpha
    configure('{FMT_MASK32, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                32'h0000_0505, 9'd256});
    convert(32'h8899_aabb);
    // full-width alpha run
    configure('{FMT_MASK32, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST,
                32'hffff_ffff, 9'd256});
    convert(32'hc3ff_ffff);

    // bad rgb masks: overlap, empty, scattered
    configure('{FMT_MASK32, 32'h00ff_0000, 32'h00ff_0000, BLUE_MASK_RST,
                ALPHA_MASK_RST, 9'd256});
    convert(32'h1234_5678);
    configure('{FMT_MASK32, RED_MASK_RST, GREEN_MASK_RST, 32'h0000_0000,
                ALPHA_MASK_RST, 9'd256});
    convert(32'h1234_5678);
    configure('{FMT_MASK32, RED_MASK_RST, 32'h0000_f0f0, BLUE_MASK_RST,
                ALPHA_MASK_RST, 9'd256});
    convert(32'h1234_5678);

    // random settings and items
    for (p = 0; p < RANDOM_PHASES; p++) run_random_phase(PHASE_ITEMS);

    hold_until_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d input items (%0d palette loads) and %0d results",
             rgba_sb.n_inputs, rgba_sb.n_writes, rgba_sb.n_results);
    $display("over %0d register settings in all pixel formats, good and bad masks",
             n_settings);
    if (rgba_sb.errors == 0 && rgba_sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
